>>> rtl/pmst_pkg.sv
// Shared types and constants for the Prim spanning tree block.
// Used by pmst_engine and prim_minimum_spanning_tree; no dependencies.
package pmst_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VTX_W        = 3;
  localparam int CNT_W        = 4;
  localparam int WEIGHT_W     = 16;
  localparam int KEY_W        = WEIGHT_W + 1;
  localparam int ADDR_W       = 2 * VTX_W;
  localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;

  localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_RELAX,
    ST_OUT_RD,
    ST_EMIT
  } state_t;

  // one tree edge handed from the engine to the output register
  typedef struct packed {
    logic                last;
    logic                reachable;
    logic [WEIGHT_W-1:0] weight;
    logic [VTX_W-1:0]    child;
    logic [VTX_W-1:0]    parent;
  } edge_t;

endpackage

>>> rtl/pmst_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pmst_engine.sv
// Prim sequencer: key, parent and tree-membership registers, one shared
// compare unit, matrix read addressing and edge emission. Uses pmst_pkg.
module pmst_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pmst_pkg::CNT_W-1:0]     n,
  output logic [pmst_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [pmst_pkg::WEIGHT_W-1:0]  ram_rdata,
  output logic                           busy,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pmst_pkg::edge_t                res
);

  pmst_pkg::state_t state, state_next;

  logic [pmst_pkg::KEY_W-1:0] best_key    [pmst_pkg::MAX_VERTICES];
  logic [pmst_pkg::VTX_W-1:0] tree_parent [pmst_pkg::MAX_VERTICES];
  logic [pmst_pkg::MAX_VERTICES-1:0] in_tree;

  logic [pmst_pkg::VTX_W-1:0] vidx;
  logic [pmst_pkg::KEY_W-1:0] lowest;
  logic [pmst_pkg::VTX_W-1:0] pick;
  logic                       found;
  logic [pmst_pkg::VTX_W-1:0] round;
  logic [pmst_pkg::CNT_W-1:0] rlx_cnt;
  logic [pmst_pkg::VTX_W-1:0] child;

  logic [pmst_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic                       lt;
  logic [pmst_pkg::VTX_W-1:0] upd_idx;
  logic                       cand;
  logic                       found_now;
  logic [pmst_pkg::VTX_W-1:0] pick_now;
  logic                       scan_last;
  logic                       relax_last;
  logic                       round_last;
  logic                       child_last;
  logic                       child_reach;
  logic [pmst_pkg::VTX_W-1:0] child_par;
  logic                       relax_upd;

  // loop bounds
  assign scan_last  = ({1'b0, vidx} == n - pmst_pkg::CNT_W'(1));
  assign relax_last = (rlx_cnt == n);
  assign round_last = ({1'b0, round} == n - pmst_pkg::CNT_W'(2));
  assign child_last = ({1'b0, child} == n - pmst_pkg::CNT_W'(1));
  assign upd_idx    = rlx_cnt[pmst_pkg::VTX_W-1:0] - pmst_pkg::VTX_W'(1);

  // shared compare unit: key scan in select, weight against key in relax
  always_comb begin
    cmp_a = best_key[vidx];
    cmp_b = lowest;
    if (state == pmst_pkg::ST_RELAX) begin
      cmp_a = {1'b0, ram_rdata};
      cmp_b = best_key[upd_idx];
    end
  end
  assign lt = (cmp_a < cmp_b);

  // select bookkeeping for the current scan position
  assign cand      = !in_tree[vidx] && lt;
  assign found_now = found || cand;
  assign pick_now  = cand ? vidx : pick;
  assign relax_upd = (rlx_cnt != '0) && (ram_rdata != '0) && !in_tree[upd_idx] && lt;

  // output edge fields
  assign child_reach = (best_key[child] != pmst_pkg::KEY_INF);
  assign child_par   = child_reach ? tree_parent[child] : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmst_pkg::ST_IDLE: begin
        if (start) state_next = pmst_pkg::ST_SEL;
      end
      pmst_pkg::ST_SEL: begin
        if (scan_last) state_next = found_now ? pmst_pkg::ST_RELAX : pmst_pkg::ST_OUT_RD;
      end
      pmst_pkg::ST_RELAX: begin
        if (relax_last) state_next = round_last ? pmst_pkg::ST_OUT_RD : pmst_pkg::ST_SEL;
      end
      pmst_pkg::ST_OUT_RD: begin
        state_next = pmst_pkg::ST_EMIT;
      end
      pmst_pkg::ST_EMIT: begin
        if (res_ready) state_next = child_last ? pmst_pkg::ST_IDLE : pmst_pkg::ST_OUT_RD;
      end
      default: begin
        state_next = pmst_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: matrix read address and result handshake
  always_comb begin
    ram_raddr = {child, child_par};
    res_valid = 1'b0;
    busy      = 1'b1;
    case (state)
      pmst_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      pmst_pkg::ST_RELAX: begin
        ram_raddr = {pick, rlx_cnt[pmst_pkg::VTX_W-1:0]};
      end
      pmst_pkg::ST_EMIT: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res.last      = child_last;
  assign res.reachable = child_reach;
  assign res.weight    = child_reach ? ram_rdata : '0;
  assign res.child     = child;
  assign res.parent    = child_par;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key, parent and tree registers plus loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < pmst_pkg::MAX_VERTICES; v++) begin
        best_key[v]    <= pmst_pkg::KEY_INF;
        tree_parent[v] <= '0;
      end
      in_tree <= '0;
      vidx    <= '0;
      lowest  <= pmst_pkg::KEY_INF;
      pick    <= '0;
      found   <= 1'b0;
      round   <= '0;
      rlx_cnt <= '0;
      child   <= '0;
    end else begin
      case (state)
        pmst_pkg::ST_IDLE: begin
          if (start) begin
            // vertex 0 starts at key zero, all others at infinity
            for (int v = 0; v < pmst_pkg::MAX_VERTICES; v++) begin
              best_key[v]    <= (v == 0) ? pmst_pkg::KEY_W'(0) : pmst_pkg::KEY_INF;
              tree_parent[v] <= '0;
            end
            in_tree     <= '0;
            round       <= '0;
            vidx        <= '0;
            lowest      <= pmst_pkg::KEY_INF;
            found       <= 1'b0;
          end
        end
        pmst_pkg::ST_SEL: begin
          if (cand) begin
            lowest <= best_key[vidx];
            pick   <= vidx;
            found  <= 1'b1;
          end
          vidx <= vidx + pmst_pkg::VTX_W'(1);
          if (scan_last) begin
            rlx_cnt <= '0;
            child   <= pmst_pkg::VTX_W'(1);
            if (found_now) in_tree[pick_now] <= 1'b1;
          end
        end
        pmst_pkg::ST_RELAX: begin
          // data for the previous column arrives while the next is addressed
          if (relax_upd) begin
            best_key[upd_idx]    <= {1'b0, ram_rdata};
            tree_parent[upd_idx] <= pick;
          end
          rlx_cnt <= rlx_cnt + pmst_pkg::CNT_W'(1);
          if (relax_last) begin
            round  <= round + pmst_pkg::VTX_W'(1);
            vidx   <= '0;
            lowest <= pmst_pkg::KEY_INF;
            found  <= 1'b0;
            child  <= pmst_pkg::VTX_W'(1);
          end
        end
        pmst_pkg::ST_EMIT: begin
          if (res_ready) child <= child + pmst_pkg::VTX_W'(1);
        end
        default: begin
          child <= child;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == pmst_pkg::ST_IDLE)
    else $error("start while sequencer busy");

  a_pick_in_tree: assert property (@(posedge clk) disable iff (rst)
    state == pmst_pkg::ST_RELAX |-> in_tree[pick])
    else $error("relaxing from a vertex outside the tree");

  a_last_child: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> {1'b0, res.child} == n - pmst_pkg::CNT_W'(1))
    else $error("last edge not on the final vertex");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last |=> state == pmst_pkg::ST_IDLE)
    else $error("sequencer did not finish after last edge");

  a_unreach: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.reachable |-> res.weight == '0 && res.parent == '0)
    else $error("unreachable vertex with nonzero edge");
`endif

endmodule

>>> rtl/prim_minimum_spanning_tree.sv
// Matrix entries are taken only while the sequencer is idle. After the request
// marked tlast, the engine runs up to n-1 rounds, each a key scan followed by a
// relax over one matrix read port; then each edge is read from the matrix and
// emitted. No request is taken meanwhile.
// Reset clears the sequencer, keys and tree state; vertex_count resets to 8.
// Top level: stream ports, vertex_count register, output register.
module prim_minimum_spanning_tree (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,    // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row, column, weight, zero pad
  input  logic        s_axis_tlast,   // load_done
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // parent_vertex, child_vertex, edge_weight, pad
  output logic [0:0]  m_axis_tuser,   // reachable
  output logic        m_axis_tlast    // last_edge
);

  logic [pmst_pkg::CNT_W-1:0]    vertex_count;
  logic [pmst_pkg::CNT_W-1:0]    n;
  logic                          in_fire;
  logic                          busy;
  logic [pmst_pkg::ADDR_W-1:0]   ram_raddr;
  logic [pmst_pkg::WEIGHT_W-1:0] ram_rdata;
  logic                          res_valid;
  logic                          res_ready;
  pmst_pkg::edge_t               res;
  pmst_pkg::edge_t               out_q;

  // vertex count register and its clamp to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pmst_pkg::CNT_W'(8);
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  always_comb begin
    n = vertex_count;
    if (vertex_count < pmst_pkg::CNT_W'(2)) begin
      n = pmst_pkg::CNT_W'(2);
    end else if (vertex_count > pmst_pkg::CNT_W'(pmst_pkg::MAX_VERTICES)) begin
      n = pmst_pkg::CNT_W'(pmst_pkg::MAX_VERTICES);
    end
  end

  // input requests write the matrix; tlast starts the tree run
  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  pmst_ram #(
    .WIDTH (pmst_pkg::WEIGHT_W),
    .DEPTH (pmst_pkg::MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (in_fire),
    .waddr ({s_axis_tdata[2:0], s_axis_tdata[5:3]}),
    .wdata (s_axis_tdata[21:6]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pmst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire && s_axis_tlast),
    .n         (n),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_q.weight, out_q.child, out_q.parent};
  assign m_axis_tuser = out_q.reachable;
  assign m_axis_tlast = out_q.last;

endmodule
